// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL of the 8-bit CPU ALU.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checks that an implication holds on every rising clock edge outside reset.
`define EBC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Checks that a signal condition holds on every rising clock edge outside reset.
`define EBC_ASSERT_NOW(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`else
`define EBC_ASSERT(label, clk, rst, prop, msg)
`define EBC_ASSERT_NOW(label, clk, rst, cond, msg)
`endif

`endif

// ===== src/ebcalu_pkg.sv =====
// Types and constants for the 8-bit CPU ALU.
// No dependencies; used by ebcalu_core and the top level.
`timescale 1ns / 1ps

package ebcalu_pkg;

  typedef enum logic [4:0] {
    KIND_ADD   = 5'd0,
    KIND_ADC   = 5'd1,
    KIND_SUB   = 5'd2,
    KIND_SBC   = 5'd3,
    KIND_AND   = 5'd4,
    KIND_XOR   = 5'd5,
    KIND_OR    = 5'd6,
    KIND_CP    = 5'd7,
    KIND_INC   = 5'd8,
    KIND_DEC   = 5'd9,
    KIND_ADD16 = 5'd10,
    KIND_RLCA  = 5'd11,
    KIND_RRCA  = 5'd12,
    KIND_RLA   = 5'd13,
    KIND_RRA   = 5'd14,
    KIND_DAA   = 5'd15,
    KIND_CPL   = 5'd16,
    KIND_SCF   = 5'd17,
    KIND_CCF   = 5'd18,
    KIND_INC16 = 5'd19,
    KIND_DEC16 = 5'd20
  } alu_kind_t;

  // Flag bit positions within the 4-bit flag nibble.
  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  // Decimal adjust constants.
  localparam logic [7:0] DAA_LIMIT = 8'h99;
  localparam logic [7:0] DAA_LO    = 8'h06;
  localparam logic [7:0] DAA_HI    = 8'h60;
  localparam logic [3:0] BCD_MAX   = 4'd9;

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] first_operand;
    logic [15:0] second_operand;
    logic [3:0]  flags_in;
  } op_t;

  typedef struct packed {
    logic [15:0] result_value;
    logic [3:0]  flags_out;
    logic        writes_result;
  } res_t;

endpackage

// ===== src/ebcalu_core.sv =====
// Combinational datapath of the 8-bit CPU ALU: value, flags and write-back.
// Depends on ebcalu_pkg.
`timescale 1ns / 1ps

module ebcalu_core (
  input  ebcalu_pkg::op_t  op,
  output ebcalu_pkg::res_t res
);

  logic [7:0]  a;
  logic [7:0]  b;
  logic [15:0] p;
  logic [15:0] q;
  logic        fz;
  logic        fn;
  logic        fh;
  logic        fc;
  logic        cin;

  logic [8:0]  add9;
  logic [4:0]  add_h;
  logic [8:0]  sub9;
  logic [4:0]  sub_h;
  logic [7:0]  inc8;
  logic [7:0]  dec8;
  logic [16:0] add17;
  logic [12:0] add13;
  logic        daa_hi;
  logic        daa_lo;
  logic [7:0]  daa_val;
  logic [7:0]  r8;

  logic [15:0] r;
  logic [3:0]  nf;
  logic        wr;

  assign a   = op.first_operand[7:0];
  assign b   = op.second_operand[7:0];
  assign p   = op.first_operand;
  assign q   = op.second_operand;
  assign fz  = op.flags_in[ebcalu_pkg::FLAG_Z];
  assign fn  = op.flags_in[ebcalu_pkg::FLAG_N];
  assign fh  = op.flags_in[ebcalu_pkg::FLAG_H];
  assign fc  = op.flags_in[ebcalu_pkg::FLAG_C];

  // Carry in only for adc / sbc.
  assign cin = fc && (op.kind == ebcalu_pkg::KIND_ADC || op.kind == ebcalu_pkg::KIND_SBC);

  assign add9  = {1'b0, a} + {1'b0, b} + {8'd0, cin};
  assign add_h = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
  assign sub9  = {1'b0, a} - {1'b0, b} - {8'd0, cin};
  assign sub_h = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cin};
  assign inc8  = a + 8'd1;
  assign dec8  = a - 8'd1;
  assign add17 = {1'b0, p} + {1'b0, q};
  assign add13 = {1'b0, p[11:0]} + {1'b0, q[11:0]};

  // Decimal adjust: after add, corrections decided on the raw accumulator and flags; after subtract, on H and C alone.
  assign daa_hi = fn ? fc : (fc || (a > ebcalu_pkg::DAA_LIMIT));
  assign daa_lo = fn ? fh : (fh || (a[3:0] > ebcalu_pkg::BCD_MAX));
  assign daa_val = fn
    ? a - (daa_lo ? ebcalu_pkg::DAA_LO : 8'd0) - (daa_hi ? ebcalu_pkg::DAA_HI : 8'd0)
    : a + (daa_lo ? ebcalu_pkg::DAA_LO : 8'd0) + (daa_hi ? ebcalu_pkg::DAA_HI : 8'd0);

  always_comb begin
    r8 = 8'd0;
    r  = 16'd0;
    nf = op.flags_in;
    wr = 1'b1;
    unique case (op.kind)
      ebcalu_pkg::KIND_ADD, ebcalu_pkg::KIND_ADC: begin
        r8 = add9[7:0];
        r  = {8'd0, r8};
        nf = {r8 == 8'd0, 1'b0, add_h[4], add9[8]};
      end
      ebcalu_pkg::KIND_SUB, ebcalu_pkg::KIND_SBC: begin
        r8 = sub9[7:0];
        r  = {8'd0, r8};
        nf = {r8 == 8'd0, 1'b1, sub_h[4], sub9[8]};
      end
      ebcalu_pkg::KIND_CP: begin
        nf = {sub9[7:0] == 8'd0, 1'b1, sub_h[4], sub9[8]};
        wr = 1'b0;
      end
      ebcalu_pkg::KIND_AND: begin
        r8 = a & b;
        r  = {8'd0, r8};
        nf = {r8 == 8'd0, 1'b0, 1'b1, 1'b0};
      end
      ebcalu_pkg::KIND_XOR: begin
        r8 = a ^ b;
        r  = {8'd0, r8};
        nf = {r8 == 8'd0, 1'b0, 1'b0, 1'b0};
      end
      ebcalu_pkg::KIND_OR: begin
        r8 = a | b;
        r  = {8'd0, r8};
        nf = {r8 == 8'd0, 1'b0, 1'b0, 1'b0};
      end
      ebcalu_pkg::KIND_INC: begin
        r  = {8'd0, inc8};
        nf = {inc8 == 8'd0, 1'b0, a[3:0] == 4'hF, fc};
      end
      ebcalu_pkg::KIND_DEC: begin
        r  = {8'd0, dec8};
        nf = {dec8 == 8'd0, 1'b1, a[3:0] == 4'h0, fc};
      end
      ebcalu_pkg::KIND_ADD16: begin
        r  = add17[15:0];
        nf = {fz, 1'b0, add13[12], add17[16]};
      end
      ebcalu_pkg::KIND_RLCA: begin
        r  = {8'd0, a[6:0], a[7]};
        nf = {3'b000, a[7]};
      end
      ebcalu_pkg::KIND_RRCA: begin
        r  = {8'd0, a[0], a[7:1]};
        nf = {3'b000, a[0]};
      end
      ebcalu_pkg::KIND_RLA: begin
        r  = {8'd0, a[6:0], fc};
        nf = {3'b000, a[7]};
      end
      ebcalu_pkg::KIND_RRA: begin
        r  = {8'd0, fc, a[7:1]};
        nf = {3'b000, a[0]};
      end
      ebcalu_pkg::KIND_DAA: begin
        r  = {8'd0, daa_val};
        nf = {daa_val == 8'd0, fn, 1'b0, daa_hi};
      end
      ebcalu_pkg::KIND_CPL: begin
        r  = {8'd0, ~a};
        nf = {fz, 1'b1, 1'b1, fc};
      end
      ebcalu_pkg::KIND_SCF: begin
        nf = {fz, 1'b0, 1'b0, 1'b1};
        wr = 1'b0;
      end
      ebcalu_pkg::KIND_CCF: begin
        nf = {fz, 1'b0, 1'b0, ~fc};
        wr = 1'b0;
      end
      ebcalu_pkg::KIND_INC16: begin
        r = p + 16'd1;
      end
      ebcalu_pkg::KIND_DEC16: begin
        r = p - 16'd1;
      end
      default: begin
        // undefined codes: no write-back, flags pass through
        wr = 1'b0;
      end
    endcase
  end

  assign res.result_value  = r;
  assign res.flags_out     = nf;
  assign res.writes_result = wr;

endmodule

// ===== src/eight_bit_cpu_alu_with_flags.sv =====
// Top level of the 8-bit CPU ALU: input register, datapath, result register.
// Depends on ebcalu_pkg, ebcalu_core and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage
//   op channel  (op_valid / op_ready / op): one beat carries an operation code,
//     two 16-bit operands and the incoming Z/N/H/C flags.
//   res channel (res_valid / res_ready / res): one beat per op beat, in order,
//     with the result value, new flags and the write-back strobe.
// Path: an accepted op beat passes the input register, the datapath and the
//   result register, in that order, before it is presented on res.
// Throughput: one beat per cycle, sustained while res_ready stays high; the
//   datapath between the two registers is a single pass of 8/16-bit adders and flag logic.
// Stall: when res_ready is low the result register holds its beat; the input
//   register still takes one more beat, and op_ready drops only when both
//   registers are full and the receiver is stalled.
// Reset (rst, synchronous, active high) empties both registers; op_ready is
//   high in the first cycle after reset. The block holds no other state.
module eight_bit_cpu_alu_with_flags (
  input  logic             clk,
  input  logic             rst,
  input  logic             op_valid,
  output logic             op_ready,
  input  ebcalu_pkg::op_t  op,
  output logic             res_valid,
  input  logic             res_ready,
  output ebcalu_pkg::res_t res
);

  // input register
  logic             s1_valid;
  ebcalu_pkg::op_t  s1;

  // datapath output
  ebcalu_pkg::res_t core_res;

  // result register may load when empty or being drained this cycle
  logic             out_load;

  assign out_load = !res_valid || res_ready;
  // input register frees up when it is empty or hands its beat on
  assign op_ready = !s1_valid || out_load;

  ebcalu_core u_core (
    .op  (s1),
    .res (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (op_ready) begin
        s1_valid <= op_valid;
      end
      if (out_load) begin
        res_valid <= s1_valid;
      end
    end
    // payload: no reset needed
    if (op_valid && op_ready) begin
      s1 <= op;
    end
    if (out_load && s1_valid) begin
      res <= core_res;
    end
  end

  // Back-pressure only when both stages are full and the receiver stalls.
  `EBC_ASSERT(a_stall_cause, clk, rst, !op_ready |-> (s1_valid && res_valid && !res_ready), "op_ready low without a full stalled pipe")
  // An accepted beat always lands in the input register.
  `EBC_ASSERT(a_accept_lands, clk, rst, (op_valid && op_ready) |=> s1_valid, "accepted beat lost")
  // Beats without write-back carry a zero value.
  `EBC_ASSERT_NOW(a_nowr_zero, clk, rst, !(res_valid && !res.writes_result) || (res.result_value == 16'd0), "non-written result not zero")

endmodule
